[rtl/rfa_pkg.sv]
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants of the rational fraction ALU
// Widths, operation and status codes, sequencer states, shared-unit ops.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned ProdWidth  = 2 * ValueWidth;
  localparam int unsigned ShWidth    = $clog2(ProdWidth + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Shared-unit operations.
  typedef enum logic [2:0] {
    U_MUL,   // r = x * y (magnitudes, ValueWidth each)
    U_ADD,   // signed-magnitude sum of x and y
    U_SUB,   // r = x - y, borrow flag
    U_SHL,   // r = x << 1 with bit in
    U_NONE
  } uop_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_AB,    // an*bd
    S_MUL_BA,    // bn*ad
    S_MUL_N,     // an*bn, sum or cross_a
    S_MUL_D,     // ad*bd or ad*bn
    S_DIFF,      // cross_a - cross_b
    S_NUM,       // zero checks, load Euclid pair
    S_GCD_CHK,   // check y == 0
    S_MOD_INIT,
    S_MOD_STEP,  // restoring division step x % y
    S_GCD_SWAP,
    S_DIVN_INIT,
    S_DIVN_STEP, // n / g
    S_DIVD_INIT,
    S_DIVD_STEP, // d / g
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [ProdWidth-1:0] mag;
    logic                 neg;
  } smag_t;

endpackage

[rtl/rfa_alu.sv]
// ----------------------------------------------------------------------------
// rfa_alu: shared arithmetic unit
// One 32x32 multiplier, one 64-bit add/subtract and a one-bit left shift.
// ----------------------------------------------------------------------------
module rfa_alu import rfa_pkg::*; (
  input  uop_e                 op_i,
  input  smag_t                x_i,
  input  smag_t                y_i,
  input  logic                 bit_i,
  output smag_t                r_o,
  output logic                 borrow_o
);

  logic [ProdWidth:0] diff;

  assign diff = {1'b0, x_i.mag} - {1'b0, y_i.mag};

  always_comb begin
    r_o      = '0;
    borrow_o = diff[ProdWidth];
    case (op_i)
      U_MUL: begin
        r_o.mag = x_i.mag[ValueWidth-1:0] * y_i.mag[ValueWidth-1:0];
        r_o.neg = x_i.neg ^ y_i.neg;
      end
      U_ADD: begin
        if (x_i.neg == y_i.neg) begin
          r_o.mag = x_i.mag + y_i.mag;
          r_o.neg = x_i.neg;
        end else if (!diff[ProdWidth]) begin
          r_o.mag = diff[ProdWidth-1:0];
          r_o.neg = x_i.neg;
        end else begin
          r_o.mag = y_i.mag - x_i.mag;
          r_o.neg = y_i.neg;
        end
      end
      U_SUB: r_o.mag = diff[ProdWidth-1:0];
      U_SHL: r_o.mag = {x_i.mag[ProdWidth-2:0], bit_i};
      default: r_o = '0;
    endcase
    if (r_o.mag == '0) begin
      r_o.neg = 1'b0;
    end
  end

endmodule

[rtl/rational_fraction_alu_top.sv]
// ----------------------------------------------------------------------------
// rational_fraction_alu_top: exact fraction add/sub/mul/div with reduction
// Sequencer drives one shared ALU through products, GCD and division.
// ----------------------------------------------------------------------------
// Each Euclid modulo step and each final division runs the restoring divider;
//   a zero denominator goes straight to the result, and divide by zero or a
//   zero result ends after the products.
// Throughput: one transaction at a time; busy is high until the result strobe.
// Reset: asynchronous active low, returns the sequencer to idle, no result.
// The receiver cannot stall; each result shows for one cycle under done_o.
module rational_fraction_alu_top import rfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type_i,
  input  logic signed [31:0]    a_num_i,
  input  logic signed [31:0]    a_den_i,
  input  logic signed [31:0]    b_num_i,
  input  logic signed [31:0]    b_den_i,
  output logic                  done_o,
  output logic signed [31:0]    res_num_o,
  output logic [30:0]           res_den_o,
  output logic                  a_less_b_o,
  output logic                  a_equal_b_o,
  output logic [1:0]            status_o
);

  localparam logic [ShWidth-1:0] LastBit = ShWidth'(ProdWidth - 1);
  localparam logic [ProdWidth-1:0] Lim = ProdWidth'(1) << (ValueWidth - 1);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  smag_t  an_q, ad_q, bn_q, bd_q, an_d, ad_d, bn_d, bd_d;
  smag_t  ca_q, cb_q, n_q, d_q, ca_d, cb_d, n_d, d_d;
  smag_t  x_q, y_q, x_d, y_d;           // Euclid pair
  logic [ProdWidth-1:0] rem_q, rem_d, quo_q, quo_d, dvd_q, dvd_d;
  logic [ProdWidth-1:0] nm_q, nm_d;
  logic [ShWidth-1:0] cnt_q, cnt_d;
  logic   less_q, less_d, eq_q, eq_d, dneg_q, dneg_d;
  logic   done_q, done_d;
  logic signed [31:0] rnum_q, rnum_d;
  logic [30:0] rden_q, rden_d;
  logic [1:0]  st_q, st_d;

  uop_e   uop;
  smag_t  ux, uy, ur;
  logic   ubit, uborrow;

  rfa_alu u_alu (
    .op_i(uop), .x_i(ux), .y_i(uy), .bit_i(ubit), .r_o(ur), .borrow_o(uborrow)
  );

  function automatic smag_t to_sm(input logic [31:0] v);
    smag_t s;
    logic signed [ValueWidth-1:0] t;
    t = v[ValueWidth-1:0];
    s.neg = t[ValueWidth-1];
    s.mag = ProdWidth'(s.neg ? ValueWidth'(-t) : t);
    if (s.neg && t == {1'b1, {(ValueWidth-1){1'b0}}}) begin
      s.mag = ProdWidth'(1) << (ValueWidth - 1);
    end
    return s;
  endfunction

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    ca_q <= ca_d; cb_q <= cb_d; n_q <= n_d; d_q <= d_d; x_q <= x_d; y_q <= y_d;
    rem_q <= rem_d; quo_q <= quo_d; dvd_q <= dvd_d; nm_q <= nm_d; cnt_q <= cnt_d;
    less_q <= less_d; eq_q <= eq_d; dneg_q <= dneg_d;
    rnum_q <= rnum_d; rden_q <= rden_d; st_q <= st_d;
  end

  always_comb begin
    logic rneg;
    logic fits;
    smag_t tmp;
    state_d = state_q; op_d = op_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    ca_d = ca_q; cb_d = cb_q; n_d = n_q; d_d = d_q; x_d = x_q; y_d = y_q;
    rem_d = rem_q; quo_d = quo_q; dvd_d = dvd_q; nm_d = nm_q; cnt_d = cnt_q;
    less_d = less_q; eq_d = eq_q; dneg_d = dneg_q;
    rnum_d = rnum_q; rden_d = rden_q; st_d = st_q;
    done_d = 1'b0;
    uop = U_NONE; ux = '0; uy = '0; ubit = 1'b0;
    rneg = n_q.neg ^ d_q.neg;
    fits = 1'b0;
    tmp = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = op_e'(req_type_i);
          an_d = to_sm(a_num_i); ad_d = to_sm(a_den_i);
          bn_d = to_sm(b_num_i); bd_d = to_sm(b_den_i);
          less_d = 1'b0; eq_d = 1'b0; rnum_d = '0; rden_d = '0;
          if (ad_d.mag == '0 || bd_d.mag == '0) begin
            st_d = ST_ZERO_DEN;
            state_d = S_FINISH;
          end else begin
            st_d = ST_OK;
            state_d = S_MUL_AB;
          end
        end
      end
      S_MUL_AB: begin
        uop = U_MUL; ux = an_q; uy = bd_q; ca_d = ur;
        dneg_d = ad_q.neg ^ bd_q.neg;
        state_d = S_MUL_BA;
      end
      S_MUL_BA: begin
        uop = U_MUL; ux = bn_q; uy = ad_q; cb_d = ur;
        state_d = S_DIFF;
      end
      S_DIFF: begin
        tmp = cb_q;
        if (tmp.mag != '0) tmp.neg = !tmp.neg;
        uop = U_ADD; ux = ca_q; uy = tmp;
        eq_d = (ur.mag == '0);
        less_d = (ur.mag != '0) && (ur.neg != dneg_q);
        n_d = ur;
        state_d = S_MUL_N;
      end
      S_MUL_N: begin
        // numerator for add/mul/div; subtract keeps the difference in n_q
        if (op_q == OP_MUL) begin
          uop = U_MUL; ux = an_q; uy = bn_q; n_d = ur;
        end else if (op_q == OP_ADD) begin
          uop = U_ADD; ux = ca_q; uy = cb_q; n_d = ur;
        end else if (op_q == OP_DIV) begin
          n_d = ca_q;
        end
        state_d = S_MUL_D;
      end
      S_MUL_D: begin
        uop = U_MUL; ux = ad_q; uy = (op_q == OP_DIV) ? bn_q : bd_q; d_d = ur;
        state_d = S_NUM;
      end
      S_NUM: begin
        if (d_q.mag == '0) begin
          st_d = ST_DIV_ZERO;
          state_d = S_FINISH;
        end else if (n_q.mag == '0) begin
          rden_d = 31'd1;
          state_d = S_FINISH;
        end else begin
          x_d = n_q; y_d = d_q;
          state_d = S_GCD_CHK;
        end
      end
      S_GCD_CHK: begin
        state_d = (y_q.mag == '0) ? S_DIVN_INIT : S_MOD_INIT;
      end
      S_MOD_INIT: begin
        dvd_d = x_q.mag; rem_d = '0; cnt_d = LastBit;
        state_d = S_MOD_STEP;
      end
      S_MOD_STEP: begin
        // restoring step: shift in one dividend bit, subtract if it fits
        tmp.mag = {rem_q[ProdWidth-2:0], dvd_q[ProdWidth-1]};
        uop = U_SUB; ux = tmp; uy = y_q;
        if (rem_q[ProdWidth-1] || !uborrow) rem_d = ur.mag;
        else rem_d = tmp.mag;
        dvd_d = {dvd_q[ProdWidth-2:0], 1'b0};
        quo_d = {quo_q[ProdWidth-2:0], rem_q[ProdWidth-1] || !uborrow};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = (state_q == S_MOD_STEP) ? S_GCD_SWAP : state_q;
      end
      S_GCD_SWAP: begin
        x_d = y_q; y_d.mag = rem_q; y_d.neg = 1'b0;
        state_d = S_GCD_CHK;
      end
      S_DIVN_INIT: begin
        dvd_d = n_q.mag; rem_d = '0; cnt_d = LastBit;
        state_d = S_DIVN_STEP;
      end
      S_DIVN_STEP, S_DIVD_STEP: begin
        tmp.mag = {rem_q[ProdWidth-2:0], dvd_q[ProdWidth-1]};
        uop = U_SUB; ux = tmp; uy = x_q;
        if (rem_q[ProdWidth-1] || !uborrow) rem_d = ur.mag;
        else rem_d = tmp.mag;
        dvd_d = {dvd_q[ProdWidth-2:0], 1'b0};
        quo_d = {quo_q[ProdWidth-2:0], rem_q[ProdWidth-1] || !uborrow};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = (state_q == S_DIVN_STEP) ? S_DIVD_INIT : S_FINISH;
          if (state_q == S_DIVD_STEP) begin
            fits = (quo_d < Lim) && (rneg ? (nm_q <= Lim) : (nm_q < Lim));
            if (!fits) begin
              st_d = ST_OVERFLOW;
            end else begin
              rnum_d = rneg ? 32'(-nm_q) : 32'(nm_q);
              rden_d = 31'(quo_d);
            end
          end
        end
      end
      S_DIVD_INIT: begin
        nm_d = quo_q;
        dvd_d = d_q.mag; rem_d = '0; cnt_d = LastBit;
        state_d = S_DIVD_STEP;
      end
      S_FINISH: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign done_o      = done_q;
  assign res_num_o   = rnum_q;
  assign res_den_o   = rden_q;
  assign a_less_b_o  = less_q;
  assign a_equal_b_o = eq_q;
  assign status_o    = st_q;

endmodule

[tb/tb_rational_fraction_alu_top.sv]
// ----------------------------------------------------------------------------
// tb_rational_fraction_alu_top: self-checking bench for the fraction ALU
// Sends fraction pairs and operations through start/busy. An exact
// signed-magnitude predictor with Euclid reduction computes each result.
// Every done_o strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rational_fraction_alu_top import rfa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CycleLimit = 64'd80_000_000;
  localparam int unsigned     DrainCycles = 8000;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               less;
    logic               equal;
    status_e            status;
  } frac_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type_i = '0;
  logic signed [31:0] a_num_i = '0;
  logic signed [31:0] a_den_i = 32'sd1;
  logic signed [31:0] b_num_i = '0;
  logic signed [31:0] b_den_i = 32'sd1;
  logic               done_o;
  logic signed [31:0] res_num_o;
  logic [30:0]        res_den_o;
  logic               a_less_b_o;
  logic               a_equal_b_o;
  logic [1:0]         status_o;

  frac_res_t         pending_q[$];
  int unsigned       fail_cnt;
  int unsigned       sent_cnt;
  int unsigned       checked_cnt;
  int unsigned       gap_pct;
  longint unsigned   cycle_cnt;
  int unsigned       status_seen[4];

  rational_fraction_alu_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .done_o     (done_o),
    .res_num_o  (res_num_o),
    .res_den_o  (res_den_o),
    .a_less_b_o (a_less_b_o),
    .a_equal_b_o(a_equal_b_o),
    .status_o   (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  // Signed-magnitude sum; magnitudes stay below 2^63 so no carry is lost.
  function automatic void mag_add(input logic xn, input logic [63:0] xm,
                                  input logic yn, input logic [63:0] ym,
                                  output logic rn, output logic [63:0] rm);
    if (xn == yn) begin
      rn = xn;
      rm = xm + ym;
    end else if (xm >= ym) begin
      rn = xn;
      rm = xm - ym;
    end else begin
      rn = yn;
      rm = ym - xm;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic frac_res_t predict_fraction(op_e op, logic signed [31:0] an,
                                                 logic signed [31:0] ad,
                                                 logic signed [31:0] bn,
                                                 logic signed [31:0] bd);
    frac_res_t   r;
    longint      pa, pb;
    logic        ca_n, cb_n, df_n, n_n, d_n, rneg;
    logic [63:0] ca_m, cb_m, df_m, n_m, d_m, x, y, t, nm, dm;
    r = '{num: '0, den: '0, less: 1'b0, equal: 1'b0, status: ST_OK};
    if (ad == 0 || bd == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    pa = longint'(an) * longint'(bd);
    pb = longint'(bn) * longint'(ad);
    ca_n = pa < 0; ca_m = abs64(pa);
    cb_n = pb < 0; cb_m = abs64(pb);
    mag_add(ca_n, ca_m, (cb_m != 0) ? !cb_n : 1'b0, cb_m, df_n, df_m);
    if (df_m == 0) r.equal = 1'b1;
    else if (df_n != ((ad < 0) != (bd < 0))) r.less = 1'b1;
    d_n = (longint'(ad) * longint'(bd)) < 0;
    d_m = abs64(longint'(ad) * longint'(bd));
    case (op)
      OP_ADD: mag_add(ca_n, ca_m, cb_n, cb_m, n_n, n_m);
      OP_SUB: begin
        n_n = df_n;
        n_m = df_m;
      end
      OP_MUL: begin
        n_n = (longint'(an) * longint'(bn)) < 0;
        n_m = abs64(longint'(an) * longint'(bn));
      end
      default: begin
        n_n = ca_n;
        n_m = ca_m;
        d_n = (longint'(ad) * longint'(bn)) < 0;
        d_m = abs64(longint'(ad) * longint'(bn));
      end
    endcase
    if (d_m == 0) begin
      r.status = ST_DIV_ZERO;
    end else if (n_m == 0) begin
      r.den = 31'd1;
    end else begin
      x = n_m;
      y = d_m;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      nm = n_m / x;
      dm = d_m / x;
      rneg = n_n != d_n;
      if (dm < 64'h8000_0000 && (rneg ? nm <= 64'h8000_0000 : nm < 64'h8000_0000)) begin
        r.num = rneg ? 32'(-nm) : 32'(nm);
        r.den = 31'(dm);
      end else begin
        r.status = ST_OVERFLOW;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint exp);
    $display("mismatch #%0d on %s: got %0d, expected %0d (cycle %0d)",
             checked_cnt, field, got, exp, cycle_cnt);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin
    frac_res_t exp;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        exp = pending_q.pop_front();
        if (res_num_o !== exp.num) report_mismatch("res_num", res_num_o, exp.num);
        if (res_den_o !== exp.den) report_mismatch("res_den", res_den_o, exp.den);
        if (a_less_b_o !== exp.less) report_mismatch("a_less_b", a_less_b_o, exp.less);
        if (a_equal_b_o !== exp.equal) report_mismatch("a_equal_b", a_equal_b_o, exp.equal);
        if (status_o !== exp.status) report_mismatch("status", status_o, exp.status);
        status_seen[exp.status]++;
      end
      checked_cnt++;
    end
  end

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_fraction(op_e op, logic signed [31:0] an, logic signed [31:0] ad,
                               logic signed [31:0] bn, logic signed [31:0] bd);
    while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    start = 1'b1;
    req_type_i = op;
    a_num_i = an;
    a_den_i = ad;
    b_num_i = bn;
    b_den_i = bd;
    pending_q.push_back(predict_fraction(op, an, ad, bn, bd));
    sent_cnt++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value(bit nonzero);
    logic signed [31:0] v;
    case ($urandom_range(19))
      0:  v = 32'sh7fff_ffff;
      1:  v = 32'sh8000_0000;
      2:  v = ($urandom_range(1)) ? 32'sd1 : -32'sd1;
      3, 4, 5, 6: v = $urandom;
      7, 8: v = $signed($urandom_range(65535)) - 32'sd32768;
      default: v = $signed($urandom_range(40)) - 32'sd20;
    endcase
    if (nonzero && v == 0) v = 32'sd1;
    return v;
  endfunction

  task automatic test_directed();
    gap_pct = 0;
    send_fraction(OP_ADD, 1, 2, 1, 3);
    send_fraction(OP_SUB, 3, 4, -6, -8);
    send_fraction(OP_MUL, -2, 3, 9, 4);
    send_fraction(OP_DIV, 5, -7, -10, 21);
    send_fraction(OP_DIV, 5, 7, 0, 3);
    send_fraction(OP_ADD, 1, 0, 1, 3);
    send_fraction(OP_MUL, 1, 2, 1, 0);
    send_fraction(OP_DIV, 0, 0, 0, 0);
    send_fraction(OP_MUL, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 1);
    send_fraction(OP_DIV, 32'sh8000_0000, 1, -1, 1);
    send_fraction(OP_MUL, 32'sh8000_0000, 1, 1, 1);
    send_fraction(OP_ADD, 1, 32'sh8000_0000, 0, 1);
    send_fraction(OP_SUB, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_fraction(OP_ADD, 32'sh7fff_ffff, 1, 1, 1);
    send_fraction(OP_SUB, 32'sh8000_0000, 1, 0, 1);
    send_fraction(OP_ADD, 0, -5, 0, 9);
    send_fraction(OP_SUB, -1, 3, 1, -3);
    send_fraction(OP_DIV, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_fraction(OP_MUL, -1, -1, -1, -1);
    send_fraction(OP_ADD, 32'sh7fff_fffe, 32'sh7fff_ffff, 1, 32'sh7fff_fffd);
    // hold off until every result is back
    wait_drained();
  endtask

  task automatic test_random_phase(int unsigned pct, int unsigned count);
    logic signed [31:0] ad, bd;
    gap_pct = pct;
    repeat (count) begin
      ad = pick_value(1'b1);
      bd = pick_value(1'b1);
      if ($urandom_range(29) == 0) ad = 0;
      if ($urandom_range(29) == 0) bd = 0;
      send_fraction(op_e'($urandom_range(3)), pick_value(1'b0), ad,
                    ($urandom_range(24) == 0) ? 32'sd0 : pick_value(1'b0), bd);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_phase(0, 460);
    test_random_phase(71, 460);
    wait_drained();
    test_random_phase(71, 460);
    test_random_phase(15, 460);
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    $display("sent %0d transactions, checked %0d results over %0d cycles",
             sent_cnt, checked_cnt, cycle_cnt);
    $display("status mix ok/zero-den/div-zero/overflow: %0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rfa_pkg.sv
rtl/rfa_alu.sv
rtl/rational_fraction_alu_top.sv
tb/tb_rational_fraction_alu_top.sv
